FILE: hw/rtl/rsc_pkg.sv
// rsc_pkg: shared types, constants and character helpers for the radix string converter
// depends on nothing; imported by radix_string_converter_top
`default_nettype none

package rsc_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int CHAR_W         = 8;
	localparam int BASE_W         = 5;
	localparam int DIGIT_W        = 4;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0]  CHAR_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0]  CHAR_UP_F  = 8'h46;
	localparam logic [CHAR_W-1:0]  CHAR_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0]  CHAR_LO_F  = 8'h66;
	localparam logic [DIGIT_W-1:0] DEC_LIMIT  = 4'd10;
	localparam logic [BASE_W-1:0]  BASE_MIN   = 5'd2;
	localparam logic [BASE_W-1:0]  BASE_MAX   = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_READ,
		ST_EMIT
	} rsc_state_t;

	// ascii to digit value, anything unrecognised counts as zero
	function automatic logic [DIGIT_W-1:0] decode_digit(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] d;
		d = '0;
		priority if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			d = ch - CHAR_ZERO;
		end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
			d = ch - CHAR_LO_A + CHAR_W'(DEC_LIMIT);
		end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
			d = ch - CHAR_UP_A + CHAR_W'(DEC_LIMIT);
		end else begin
			d = '0;
		end
		return d[DIGIT_W-1:0];
	endfunction

	// digit value to ascii, uppercase letters
	function automatic logic [CHAR_W-1:0] encode_digit(input logic [DIGIT_W-1:0] dv);
		logic [CHAR_W-1:0] c;
		if (dv < DEC_LIMIT) begin
			c = CHAR_ZERO + CHAR_W'(dv);
		end else begin
			c = CHAR_UP_A + CHAR_W'(dv - DEC_LIMIT);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rsc_ram.sv
// rsc_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module rsc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/radix_string_converter_top.sv
// radix_string_converter_top: serial base conversion of ascii numbers, bases 2 to 16
// depends on rsc_pkg and rsc_ram
`default_nettype none

// A number arrives one character per request, most significant first, and is
// folded into a VALUE_BITS accumulator (value * source_base + digit, wrapping).
// On the request marked last_in the value is converted to dest_base and sent
// out as ascii digits, most significant first, last_out on the final digit;
// zero gives a single '0'. When source_base equals dest_base the character is
// echoed on the next cycle with last_in copied to last_out, and nothing else
// changes. Results appear for one cycle on strobe and cannot be held off.
// An echoed request leaves busy low. Any other request raises busy for a
// shift-and-add over the bits of source_base (ST_MUL), then a step to add
// the digit (ST_ADD). A last character then runs a restoring divider, one
// quotient bit per cycle, for each output digit, and reads the digits back
// from the digit ram through ST_READ and ST_EMIT, holding busy until the
// final digit is sent.
module radix_string_converter_top
	import rsc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [CHAR_W-1:0] char_in,
	input  wire logic [BASE_W-1:0] source_base,
	input  wire logic [BASE_W-1:0] dest_base,
	input  wire logic              last_in,
	output logic                   strobe,
	output logic      [CHAR_W-1:0] char_out,
	output logic                   last_out
);

	// one digit per value bit at most (base 2), so the digit ram is VALUE_BITS deep
	localparam int AW = $clog2(VALUE_BITS);
	localparam logic [AW-1:0] BIT_LAST = AW'(VALUE_BITS - 1);
	localparam logic [2:0]    MUL_LAST = 3'(BASE_W - 1);

	rsc_state_t state_q, state_d;

	// datapath registers
	logic [VALUE_BITS-1:0] value_acc_q;  // running accumulator
	logic [VALUE_BITS-1:0] work_q;       // product, then dividend / quotient
	logic [BASE_W-1:0]     sbase_q;      // multiplier, shifted out msb first
	logic [BASE_W-1:0]     dbase_q;      // clamped destination base
	logic [DIGIT_W-1:0]    digit_q;
	logic                  last_q;
	logic [2:0]            step_q;       // multiply step
	logic [AW-1:0]         bit_q;        // divide step
	logic [DIGIT_W-1:0]    rem_q;
	logic                  nz_q;         // quotient so far has a set bit
	logic [AW-1:0]         dig_idx_q;    // digit write / read pointer

	// output registers
	logic                  strobe_q;
	logic [CHAR_W-1:0]     char_out_q;
	logic                  last_out_q;

	// control
	logic                  accept;
	logic                  echo;
	logic                  take;
	logic                  div_end;
	logic                  div_more;
	logic                  ram_we;
	logic                  ram_re;

	// divider slice
	logic [BASE_W-1:0]     div_tmp;
	logic [BASE_W-1:0]     div_diff;
	logic                  div_ge;
	logic [DIGIT_W-1:0]    rem_nxt;

	logic [VALUE_BITS-1:0] sum;
	logic [DIGIT_W-1:0]    ram_rdata;
	logic [BASE_W-1:0]     dbase_clamp;

	assign accept = start && !busy;
	assign echo   = accept && (source_base == dest_base);
	assign take   = accept && (source_base != dest_base);

	// restoring division: bring down one dividend bit per cycle
	assign div_tmp  = {rem_q, work_q[VALUE_BITS-1]};
	assign div_ge   = (div_tmp >= dbase_q);
	assign div_diff = div_tmp - dbase_q;
	assign rem_nxt  = div_ge ? div_diff[DIGIT_W-1:0] : div_tmp[DIGIT_W-1:0];

	assign div_end  = (state_q == ST_DIV) && (bit_q == BIT_LAST);
	// another digit follows while the quotient is non-zero
	assign div_more = nz_q || div_ge;

	assign sum = work_q + VALUE_BITS'(digit_q);

	always_comb begin
		priority if (dest_base < BASE_MIN) begin
			dbase_clamp = BASE_MIN;
		end else if (dest_base > BASE_MAX) begin
			dbase_clamp = BASE_MAX;
		end else begin
			dbase_clamp = dest_base;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control outputs
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (take) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == MUL_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = last_q ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (div_end) begin
					ram_we = 1'b1;
					if (!div_more) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = (dig_idx_q == '0) ? ST_IDLE : ST_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// accumulator and digit pointer need a known start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_acc_q <= '0;
			dig_idx_q   <= '0;
			step_q      <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			nz_q        <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= echo || (state_q == ST_EMIT);
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
				end
				ST_ADD: begin
					// a finished number clears the accumulator for the next one
					value_acc_q <= last_q ? '0 : sum;
					bit_q       <= '0;
					rem_q       <= '0;
					nz_q        <= 1'b0;
					dig_idx_q   <= '0;
				end
				ST_DIV: begin
					if (div_end) begin
						bit_q <= '0;
						rem_q <= '0;
						nz_q  <= 1'b0;
						if (div_more) begin
							dig_idx_q <= dig_idx_q + AW'(1);
						end
					end else begin
						bit_q <= bit_q + AW'(1);
						rem_q <= rem_nxt;
						nz_q  <= nz_q || div_ge;
					end
				end
				ST_READ: begin
				end
				ST_EMIT: begin
					if (dig_idx_q != '0) begin
						dig_idx_q <= dig_idx_q - AW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			sbase_q <= source_base;
			dbase_q <= dbase_clamp;
			digit_q <= decode_digit(char_in);
			last_q  <= last_in;
			work_q  <= '0;
		end
		if (echo) begin
			char_out_q <= char_in;
			last_out_q <= last_in;
		end
		unique case (state_q)
			ST_MUL: begin
				// shift-and-add, multiplier msb first
				work_q  <= (work_q << 1) + (sbase_q[BASE_W-1] ? value_acc_q : '0);
				sbase_q <= sbase_q << 1;
			end
			ST_ADD: begin
				work_q <= sum;
			end
			ST_DIV: begin
				work_q <= {work_q[VALUE_BITS-2:0], div_ge};
			end
			ST_EMIT: begin
				char_out_q <= encode_digit(ram_rdata);
				last_out_q <= (dig_idx_q == '0);
			end
			ST_IDLE, ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	// digits land least significant first, read back in reverse
	rsc_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(VALUE_BITS)
	) u_digit_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(dig_idx_q),
		.wdata(rem_nxt),
		.re   (ram_re),
		.raddr(dig_idx_q),
		.rdata(ram_rdata)
	);

	assign strobe   = strobe_q;
	assign char_out = char_out_q;
	assign last_out = last_out_q;

	// remainder always stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({1'b0, rem_q} < dbase_q))
		else $error("divider remainder not below base");

	// a result only follows an echo or a digit read-back
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(echo) || $past(state_q == ST_EMIT)))
		else $error("result strobe without source");

	// an echoed request leaves the accumulator alone
	assert property (@(posedge clk) disable iff (!arst_n)
		echo |=> $stable(value_acc_q))
		else $error("echo disturbed accumulator");

	// the final converted digit returns the block to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_out && $past(state_q == ST_EMIT)) |-> (state_q == ST_IDLE))
		else $error("last digit sent but still busy");

endmodule

`default_nettype wire
